/* sv/ascii_to_integer_parser_top_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef ASCII_TO_INTEGER_PARSER_TOP_MACROS_SVH
`define ASCII_TO_INTEGER_PARSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define A2I_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed (same cycle)");
`define A2I_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed (next cycle)");
`else
`define A2I_ASSERT_IMPL(label, ante, cons)
`define A2I_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/a2i_pkg.sv */
// Types, character codes and digit decoding for the ASCII integer parser.
`timescale 1ns / 1ps

package a2i_pkg;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 32;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_F  = 8'h46;
    localparam logic [CH_W-1:0] CH_UC_X  = 8'h58;
    localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [CH_W-1:0] CH_LC_X  = 8'h78;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               success;
    } result_t;

    typedef struct packed {
        logic hex;
        logic negative;
        logic consumed;
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } digit_t;

    // Digit value of a character in the current base.
    function automatic digit_t digit_of(input logic [CH_W-1:0] ch, input logic hex);
        digit_t d;
        logic [CH_W-1:0] off;
        d.valid = 1'b0;
        d.val   = 4'd0;
        off     = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            off     = ch - CH_ZERO;
            d.valid = 1'b1;
            d.val   = off[3:0];
        end
        else if (hex && ch >= CH_LC_A && ch <= CH_LC_F)
        begin
            off     = ch - CH_LC_A + 8'd10;
            d.valid = 1'b1;
            d.val   = off[3:0];
        end
        else if (hex && ch >= CH_UC_A && ch <= CH_UC_F)
        begin
            off     = ch - CH_UC_A + 8'd10;
            d.valid = 1'b1;
            d.val   = off[3:0];
        end
        return d;
    endfunction

endpackage

/* sv/a2i_in_stage.sv */
// Input register for the character stream.
`timescale 1ns / 1ps

module a2i_in_stage
    import a2i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    input  logic  advance,
    output logic  vld,
    output item_t item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    // The register takes a new transfer whenever it is empty or drains this cycle.
    assign s_tready = !vld_reg || advance;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tvalid && s_tready)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

/* sv/a2i_parse_core.sv */
// Parser state and the per-character update.
`timescale 1ns / 1ps

module a2i_parse_core
    import a2i_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output logic    ends,
    output result_t result,
    output status_t status
);

    localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] LIM_DEC  = ALL_ONES / VALUE_BITS'(10);
    localparam logic [VALUE_BITS-1:0] LIM_HEX  = ALL_ONES / VALUE_BITS'(16);

    phase_t                phase_reg, phase_next, phase_proc;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_proc, acc_scaled;
    logic                  hex_reg, hex_next, hex_proc;
    logic                  neg_reg, neg_next, neg_proc;
    logic                  cons_reg, cons_next, cons_proc;
    logic                  ovf_reg, ovf_next, ovf_proc;

    digit_t                dig;
    logic                  is_nul, is_ws, is_minus, is_plus, is_zero, is_x;
    logic                  skip_mark, take, mark, over_lim;
    logic [VALUE_BITS-1:0] signed_val;
    logic [VALUE_BITS+VALUE_W-1:0] wide_val;

    assign dig       = digit_of(item.ch, hex_reg);
    assign is_nul    = (item.ch == CH_NUL);
    assign is_ws     = (item.ch == CH_SPACE) || (item.ch == CH_TAB);
    assign is_minus  = (item.ch == CH_MINUS);
    assign is_plus   = (item.ch == CH_PLUS);
    assign is_zero   = (item.ch == CH_ZERO);
    assign is_x      = (item.ch == CH_LC_X) || (item.ch == CH_UC_X);
    assign skip_mark = is_ws || is_minus || is_plus || is_zero;
    assign ends      = is_nul || item.last;

    // Next phase.
    always_comb
    begin
        phase_proc = phase_reg;
        if (!is_nul)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (is_minus || is_plus)
                    begin
                        phase_proc = PH_DIGITS;
                    end
                    else if (is_zero)
                    begin
                        phase_proc = PH_ZERO;
                    end
                    else if (!is_ws)
                    begin
                        phase_proc = dig.valid ? PH_DIGITS : PH_STOP;
                    end
                end
                PH_ZERO:
                begin
                    if (is_x)
                    begin
                        phase_proc = PH_DIGITS;
                    end
                    else
                    begin
                        phase_proc = dig.valid ? PH_DIGITS : PH_STOP;
                    end
                end
                PH_DIGITS: phase_proc = dig.valid ? PH_DIGITS : PH_STOP;
                PH_STOP:   phase_proc = PH_STOP;
            endcase
        end
        if (!fire)
        begin
            phase_next = phase_reg;
        end
        else if (ends)
        begin
            phase_next = PH_SKIP;
        end
        else
        begin
            phase_next = phase_proc;
        end
    end

    // Accumulator and flags.
    always_comb
    begin
        take = !is_nul && dig.valid &&
               (((phase_reg == PH_SKIP) && !skip_mark) ||
                ((phase_reg == PH_ZERO) && !is_x) ||
                (phase_reg == PH_DIGITS));
        mark = !is_nul &&
               (((phase_reg == PH_SKIP) && skip_mark) ||
                ((phase_reg == PH_ZERO) && is_x));

        // Times ten is eight times plus two times.
        acc_scaled = hex_reg ? (acc_reg << 4) : ((acc_reg << 3) + (acc_reg << 1));
        over_lim   = hex_reg ? (acc_reg > LIM_HEX) : (acc_reg > LIM_DEC);

        acc_proc  = take ? (acc_scaled + VALUE_BITS'(dig.val)) : acc_reg;
        ovf_proc  = ovf_reg || (take && over_lim);
        cons_proc = cons_reg || take || mark;
        neg_proc  = neg_reg || (!is_nul && (phase_reg == PH_SKIP) && is_minus);
        hex_proc  = hex_reg || (!is_nul && (phase_reg == PH_ZERO) && is_x);

        if (!fire)
        begin
            acc_next  = acc_reg;
            ovf_next  = ovf_reg;
            cons_next = cons_reg;
            neg_next  = neg_reg;
            hex_next  = hex_reg;
        end
        else if (ends)
        begin
            acc_next  = '0;
            ovf_next  = 1'b0;
            cons_next = 1'b0;
            neg_next  = 1'b0;
            hex_next  = 1'b0;
        end
        else
        begin
            acc_next  = acc_proc;
            ovf_next  = ovf_proc;
            cons_next = cons_proc;
            neg_next  = neg_proc;
            hex_next  = hex_proc;
        end
    end

    // Result as it stands after the current character.
    always_comb
    begin
        signed_val     = (cons_proc && neg_proc) ? (VALUE_BITS'(0) - acc_proc) : acc_proc;
        wide_val       = {{VALUE_W{1'b0}}, signed_val};
        result.value   = wide_val[VALUE_W-1:0];
        result.success = cons_proc && !ovf_proc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            hex_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            cons_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            hex_reg   <= hex_next;
            neg_reg   <= neg_next;
            cons_reg  <= cons_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign status.hex      = hex_reg;
    assign status.negative = neg_reg;
    assign status.consumed = cons_reg;

endmodule

/* sv/a2i_out_stage.sv */
// Result register on the master side.
`timescale 1ns / 1ps

module a2i_out_stage
    import a2i_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_result
);

    logic    vld_reg;
    logic    vld_next;
    result_t result_reg;

    // Free when empty or when the held result leaves this cycle.
    assign free = !vld_reg || m_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_result = result_reg;

endmodule

/* sv/ascii_to_integer_parser_top.sv */
// Top level of the character-serial ASCII to integer parser.
// Usage:
// The slave channel carries one character per transfer on s_tdata; s_tlast
// marks the final character of a string, and a NUL character also ends it
// without being parsed. Leading blanks, an optional sign or a 0x prefix are
// recognized, then decimal or hex digits are accumulated.
// The master channel delivers one transfer per string: m_tdata holds the
// 32-bit value (two's complement when negated) and m_tuser the success flag.
// A character is accepted every cycle unless a string end waits on a full
// output register. Each one is held in the input register, then parsed by the
// shift-add accumulator update; a string's result moves to the output register.
// When the receiver stalls, the result waits in the output register while
// one more string can run up to its end; after that s_tready drops.
// Reset empties both registers and returns the parser to blank skipping.
`timescale 1ns / 1ps
`include "ascii_to_integer_parser_top_macros.svh"

module ascii_to_integer_parser_top
    import a2i_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [0:0]  m_tuser    // [0] success
);

    item_t   s_item;
    item_t   in_item;
    logic    in_vld;
    logic    advance;
    logic    core_ends;
    logic    out_free;
    logic    out_load;
    result_t core_result;
    result_t m_result;
    status_t core_status;

    assign s_item.ch   = s_tdata;
    assign s_item.last = s_tlast;

    // A character that does not end a string never waits on the output side.
    assign advance  = in_vld && (!core_ends || out_free);
    assign out_load = advance && core_ends;

    a2i_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (advance),
        .vld      (in_vld),
        .item     (in_item)
    );

    a2i_parse_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item),
        .ends   (core_ends),
        .result (core_result),
        .status (core_status)
    );

    a2i_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .result   (core_result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata    = m_result.value;
    assign m_tuser[0] = m_result.success;

    `A2I_ASSERT_IMPL(a_hex_needs_consumed, core_status.hex, core_status.consumed)
    `A2I_ASSERT_IMPL(a_neg_needs_consumed, core_status.negative, core_status.consumed)
    `A2I_ASSERT_IMPL(a_empty_in_ready, !in_vld, s_tready)
    `A2I_ASSERT_NEXT(a_end_gives_result, in_vld && core_ends && out_free, m_tvalid)

endmodule
